// ===== rtl/hvbc_pkg.sv =====
package hvbc_pkg;

   localparam int NUM_REGS     = 8;
   localparam int CODE_WIDTH   = 10;
   localparam int REG_IDX_WIDTH = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int VOL_WIDTH    = 5;
   localparam int BRI_WIDTH    = 4;
   localparam int VOLUME_MAX_DEFAULT = 20;
   localparam int BRIGHT_MAX_DEFAULT = 10;

   localparam logic [15:0] EV_KEY = 16'd1;

   localparam logic [REG_IDX_WIDTH-1:0] REG_MENU   = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_POWER  = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_SELECT = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_START  = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_LEFT1  = 3'd4;
   localparam logic [REG_IDX_WIDTH-1:0] REG_RIGHT1 = 3'd5;
   localparam logic [REG_IDX_WIDTH-1:0] REG_LEFT2  = 3'd6;
   localparam logic [REG_IDX_WIDTH-1:0] REG_RIGHT2 = 3'd7;

   localparam logic [CODE_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
      10'd1, 10'd116, 10'd97, 10'd28, 10'd18, 10'd20, 10'd15, 10'd14
   };

   typedef enum logic [1:0] {
      VAL_RELEASE = 2'd0,
      VAL_PRESS   = 2'd1,
      VAL_REPEAT  = 2'd2
   } val_type;

   typedef enum logic [2:0] {
      K_IGNORE,
      K_OTHER,
      K_MENU,
      K_POWER,
      K_SELECT,
      K_START,
      K_LEFT,
      K_RIGHT
   } kind_type;

   typedef struct packed {
      logic [15:0]           event_type;
      logic [CODE_WIDTH-1:0] key_code;
      logic [7:0]            key_value;
   } req_type;

   typedef struct packed {
      logic [VOL_WIDTH-1:0] volume_level;
      logic [BRI_WIDTH-1:0] brightness_level;
      logic                 volume_changed;
      logic                 brightness_changed;
      logic                 reboot_request;
   } rsp_type;

   typedef struct packed {
      kind_type kind;
      val_type  val;
   } cmd_type;

endpackage

// ===== rtl/hotkey_volume_brightness_control.sv =====
// Hotkey volume and brightness control.
// Input channel (req_*): one key event word per accepted handshake, carrying
// event type, key code and key value. Result channel (rsp_*): exactly one word
// per event with the current volume and brightness levels and the flags for a
// level change or a completed menu+power reboot chord.
// Config port (csr_*): eight key-code registers, written with csr_we high;
// write them only while no event is in flight.
// An accepted event is written into the two-entry command queue behind the
// classifier and then into the output register, where its result word is valid;
// a stall on rsp_ready can hold the event in the queue.
// Throughput: one event per cycle while rsp_ready does not stall the result word;
// the executing stage updates the held flags and both levels as it takes each event.
// Reset: levels go to zero, held flags and the repeat toggle clear, the key
// codes return to their defaults and the queue empties.
// Stall: while rsp_ready is low the result word holds; the queue keeps
// accepting events until its two entries are full, then req_ready drops.
module hotkey_volume_brightness_control
   import hvbc_pkg::*;
#(
   parameter int VOLUME_MAX = VOLUME_MAX_DEFAULT,
   parameter int BRIGHT_MAX = BRIGHT_MAX_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [REG_IDX_WIDTH-1:0] csr_index,
   input  logic [CODE_WIDTH-1:0]    csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data
);

   logic    q_push, q_ready, q_pop, q_valid;
   cmd_type q_wdata, q_rdata;

   hvbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_wdata),
      .q_ready   (q_ready)
   );

   hvbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_data   (q_rdata),
      .pop_valid  (q_valid)
   );

   hvbc_back #(
      .VOLUME_MAX (VOLUME_MAX),
      .BRIGHT_MAX (BRIGHT_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/hvbc_front.sv =====
module hvbc_front
   import hvbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [REG_IDX_WIDTH-1:0] csr_index,
   input  logic [CODE_WIDTH-1:0]    csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     q_push,
   output cmd_type                  q_data,
   input  logic                     q_ready
);

   logic [CODE_WIDTH-1:0] code_ff [NUM_REGS];
   logic [CODE_WIDTH-1:0] code_in [NUM_REGS];

   always_comb begin
      code_in = code_ff;
      if (csr_we) begin
         code_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= REG_RESET;
      end else begin
         code_ff <= code_in;
      end
   end

   // priority: menu, power, select, start, left one, left two, right one, right two
   always_comb begin
      q_data.val = val_type'(req_data.key_value[1:0]);
      if (req_data.event_type != EV_KEY || req_data.key_value > 8'(VAL_REPEAT)) begin
         q_data.kind = K_IGNORE;
      end else if (req_data.key_code == code_ff[REG_MENU]) begin
         q_data.kind = K_MENU;
      end else if (req_data.key_code == code_ff[REG_POWER]) begin
         q_data.kind = K_POWER;
      end else if (req_data.key_code == code_ff[REG_SELECT]) begin
         q_data.kind = K_SELECT;
      end else if (req_data.key_code == code_ff[REG_START]) begin
         q_data.kind = K_START;
      end else if (req_data.key_code == code_ff[REG_LEFT1] ||
                   req_data.key_code == code_ff[REG_LEFT2]) begin
         q_data.kind = K_LEFT;
      end else if (req_data.key_code == code_ff[REG_RIGHT1] ||
                   req_data.key_code == code_ff[REG_RIGHT2]) begin
         q_data.kind = K_RIGHT;
      end else begin
         q_data.kind = K_OTHER;
      end
   end

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

endmodule

// ===== rtl/hvbc_queue.sv =====
module hvbc_queue
   import hvbc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    push_ready,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    pop_valid
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   cmd_type                entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != CNT_WIDTH'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/hvbc_back.sv =====
module hvbc_back
   import hvbc_pkg::*;
#(
   parameter int VOLUME_MAX = VOLUME_MAX_DEFAULT,
   parameter int BRIGHT_MAX = BRIGHT_MAX_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [VOL_WIDTH-1:0] VOL_TOP =
      VOL_WIDTH'((VOLUME_MAX > (2**VOL_WIDTH - 1)) ? (2**VOL_WIDTH - 1) : VOLUME_MAX);
   localparam logic [BRI_WIDTH-1:0] BRI_TOP =
      BRI_WIDTH'((BRIGHT_MAX > (2**BRI_WIDTH - 1)) ? (2**BRI_WIDTH - 1) : BRIGHT_MAX);

   logic                 select_ff, select_in;
   logic                 start_ff, start_in;
   logic                 menu_ff, menu_in;
   logic                 power_ff, power_in;
   logic                 phase_ff, phase_in;
   logic                 halted_ff, halted_in;
   logic [VOL_WIDTH-1:0] volume_ff, volume_in;
   logic [BRI_WIDTH-1:0] bright_ff, bright_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 act, vch, bch, reboot;

   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      select_in = select_ff;
      start_in  = start_ff;
      menu_in   = menu_ff;
      power_in  = power_ff;
      phase_in  = phase_ff;
      halted_in = halted_ff;
      volume_in = volume_ff;
      bright_in = bright_ff;
      act       = 1'b0;
      vch       = 1'b0;
      bch       = 1'b0;
      reboot    = 1'b0;
      if (!halted_ff && q_data.kind != K_IGNORE) begin
         case (q_data.kind) inside
            K_MENU: begin
               if (q_data.val != VAL_REPEAT) menu_in = (q_data.val == VAL_PRESS);
            end
            K_POWER: begin
               if (q_data.val != VAL_REPEAT) power_in = (q_data.val == VAL_PRESS);
            end
            K_SELECT: begin
               if (q_data.val != VAL_REPEAT) select_in = (q_data.val == VAL_PRESS);
            end
            K_START: begin
               if (q_data.val != VAL_REPEAT) start_in = (q_data.val == VAL_PRESS);
            end
            K_LEFT, K_RIGHT: begin
               if (q_data.val == VAL_REPEAT) begin
                  act      = phase_ff;
                  phase_in = !phase_ff;
               end else begin
                  act      = (q_data.val == VAL_PRESS);
                  phase_in = 1'b0;
               end
               if (act && select_ff && !start_ff) begin
                  if (q_data.kind == K_LEFT && volume_ff != '0) begin
                     volume_in = volume_ff - 1'b1;
                     vch       = 1'b1;
                  end else if (q_data.kind == K_RIGHT && volume_ff < VOL_TOP) begin
                     volume_in = volume_ff + 1'b1;
                     vch       = 1'b1;
                  end
               end else if (act && start_ff && !select_ff) begin
                  if (q_data.kind == K_LEFT && bright_ff != '0) begin
                     bright_in = bright_ff - 1'b1;
                     bch       = 1'b1;
                  end else if (q_data.kind == K_RIGHT && bright_ff < BRI_TOP) begin
                     bright_in = bright_ff + 1'b1;
                     bch       = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         if (menu_in && power_in) begin
            menu_in   = 1'b0;
            power_in  = 1'b0;
            reboot    = 1'b1;
            halted_in = 1'b1;
         end
      end
      rsp_data_in.volume_level       = volume_in;
      rsp_data_in.brightness_level   = bright_in;
      rsp_data_in.volume_changed     = vch;
      rsp_data_in.brightness_changed = bch;
      rsp_data_in.reboot_request     = reboot;
      rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff    <= 1'b0;
         start_ff     <= 1'b0;
         menu_ff      <= 1'b0;
         power_ff     <= 1'b0;
         phase_ff     <= 1'b0;
         halted_ff    <= 1'b0;
         volume_ff    <= '0;
         bright_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            select_ff <= select_in;
            start_ff  <= start_in;
            menu_ff   <= menu_in;
            power_ff  <= power_in;
            phase_ff  <= phase_in;
            halted_ff <= halted_in;
            volume_ff <= volume_in;
            bright_ff <= bright_in;
         end
      end
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/hvbc_checker.sv =====
module hvbc_checker
   import hvbc_pkg::*;
#(
   parameter int VOLUME_MAX = VOLUME_MAX_DEFAULT,
   parameter int BRIGHT_MAX = BRIGHT_MAX_DEFAULT
)
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam logic [VOL_WIDTH-1:0] VOL_TOP =
      VOL_WIDTH'((VOLUME_MAX > (2**VOL_WIDTH - 1)) ? (2**VOL_WIDTH - 1) : VOLUME_MAX);
   localparam logic [BRI_WIDTH-1:0] BRI_TOP =
      BRI_WIDTH'((BRIGHT_MAX > (2**BRI_WIDTH - 1)) ? (2**BRI_WIDTH - 1) : BRIGHT_MAX);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.volume_level <= VOL_TOP && rsp_data.brightness_level <= BRI_TOP)
      else $error("level beyond its maximum");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.volume_changed, rsp_data.brightness_changed,
                              rsp_data.reboot_request}))
      else $error("more than one event flag set");

endmodule

bind hotkey_volume_brightness_control hvbc_checker #(
   .VOLUME_MAX (VOLUME_MAX),
   .BRIGHT_MAX (BRIGHT_MAX)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
